@@ src/bmed_pkg.sv @@
// Shared types and constants for the biphase mark edge decoder.
// No dependencies; imported by every module of the block.
package bmed_pkg;

    localparam int TIME_W    = 32;
    localparam int WIN_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int LEVEL_W   = 6;

    // Request function codes
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_MAX = 2'd3;

    // Configuration reset values
    localparam logic [WIN_W-1:0] FULL_MIN_RST = 24'd1800;
    localparam logic [WIN_W-1:0] FULL_MAX_RST = 24'd2200;
    localparam logic [WIN_W-1:0] HALF_MIN_RST = 24'd800;
    localparam logic [WIN_W-1:0] HALF_MAX_RST = 24'd1200;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] edge_time;
    } t_in_req;

    typedef struct packed {
        logic               bit_queued;
        logic               bit_dropped;
        logic               pop_valid;
        logic               pop_bit;
        logic               pop_timeout;
        logic [LEVEL_W-1:0] fill_level;
        logic [LEVEL_W-1:0] peak_fill;
    } t_out_res;

    typedef struct packed {
        logic [WIN_W-1:0] full_min;
        logic [WIN_W-1:0] full_max;
        logic [WIN_W-1:0] half_min;
        logic [WIN_W-1:0] half_max;
    } t_cfg_regs;

    typedef enum logic [1:0] {
        CMD_NOP  = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      bit_val;
        logic      timeout;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_START = 3'b010,
        PH_HALF  = 3'b100
    } t_phase;

endpackage

@@ src/bmed_front.sv @@
// Front end: takes requests, measures edge intervals, runs the decode
// state machine and emits one command per request. Depends on bmed_pkg.
module bmed_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmed_pkg::t_cfg_regs i_cfg,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  bmed_pkg::t_in_req i_req,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output bmed_pkg::t_cmd    o_cmd
);
    import bmed_pkg::*;

    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_prev_edge, n_prev_edge;
    logic [TIME_W-1:0] r_prev_bit, n_prev_bit;

    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] spacing;
    logic              full_hit;
    logic              half_hit;
    logic              spacing_ok;
    logic              decoded;
    logic              dec_val;
    logic              fire;

    assign o_req_ready = i_cmd_ready;
    assign o_cmd_valid = i_req_valid;
    assign fire        = i_req_valid && i_cmd_ready;

    assign interval = i_req.edge_time - r_prev_edge;
    assign spacing  = i_req.edge_time - r_prev_bit;

    assign full_hit = (interval >= TIME_W'(i_cfg.full_min))
                   && (interval <= TIME_W'(i_cfg.full_max));
    assign half_hit = (interval >= TIME_W'(i_cfg.half_min))
                   && (interval <= TIME_W'(i_cfg.half_max));
    assign spacing_ok = (spacing >= TIME_W'(i_cfg.full_min))
                     && (spacing <= TIME_W'(i_cfg.full_max));

    always_comb begin
        n_phase     = r_phase;
        n_prev_edge = r_prev_edge;
        n_prev_bit  = r_prev_bit;
        decoded     = 1'b0;
        dec_val     = 1'b0;
        if (i_req.func == FUNC_EDGE) begin
            n_prev_edge = i_req.edge_time;
            unique case (r_phase)
                PH_WAIT: begin
                    n_phase = PH_START;
                end
                PH_START: begin
                    if (full_hit) begin
                        decoded = 1'b1;
                    end else if (half_hit) begin
                        n_phase = PH_HALF;
                    end
                end
                PH_HALF: begin
                    if (half_hit) begin
                        decoded = 1'b1;
                        dec_val = 1'b1;
                    end
                    n_phase = PH_START;
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
            if (decoded) begin
                n_prev_bit = i_req.edge_time;
            end
        end
    end

    always_comb begin
        o_cmd.bit_val = dec_val;
        o_cmd.timeout = !spacing_ok;
        if (i_req.func == FUNC_POP) begin
            o_cmd.kind = CMD_POP;
        end else if (decoded) begin
            o_cmd.kind = CMD_PUSH;
        end else begin
            o_cmd.kind = CMD_NOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_prev_edge <= '0;
            r_prev_bit  <= '0;
        end else if (fire) begin
            r_phase     <= n_phase;
            r_prev_edge <= n_prev_edge;
            r_prev_bit  <= n_prev_bit;
        end
    end

endmodule

@@ src/bmed_cmd_queue.sv @@
// Two-entry command queue that decouples front and back.
// Depends on bmed_pkg.
module bmed_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bmed_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bmed_pkg::t_cmd o_pop_cmd
);
    import bmed_pkg::*;

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_count = r_count;
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

@@ src/bmed_back.sv @@
// Back end: executes commands against the bit FIFO, tracks fill and
// peak, and holds the result register. Depends on bmed_pkg.
module bmed_back #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  bmed_pkg::t_cmd     i_cmd,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output bmed_pkg::t_out_res o_res
);
    import bmed_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [1:0]       r_mem [FIFO_DEPTH];
    logic [1:0]       r_rd_data;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_peak, n_peak;

    logic             r_b_valid;
    logic             r_b_queued;
    logic             r_b_dropped;
    logic             r_b_pop_valid;

    logic             go;
    logic             do_write;
    logic             do_read;
    logic             full;
    logic             empty;

    assign o_cmd_ready = !r_b_valid || i_res_ready;
    assign go          = i_cmd_valid && o_cmd_ready;
    assign full        = (r_count == CNT_W'(FIFO_DEPTH));
    assign empty       = (r_count == '0);
    assign do_write    = go && (i_cmd.kind == CMD_PUSH) && !full;
    assign do_read     = go && (i_cmd.kind == CMD_POP) && !empty;

    always_comb begin
        n_count = r_count;
        if (do_write) begin
            n_count = r_count + 1'b1;
        end else if (do_read) begin
            n_count = r_count - 1'b1;
        end
        n_peak = (n_count > r_peak) ? n_count : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
            r_peak        <= '0;
            r_b_valid     <= 1'b0;
            r_b_queued    <= 1'b0;
            r_b_dropped   <= 1'b0;
            r_b_pop_valid <= 1'b0;
        end else begin
            if (go) begin
                r_count       <= n_count;
                r_peak        <= n_peak;
                r_b_queued    <= do_write;
                r_b_dropped   <= (i_cmd.kind == CMD_PUSH) && full;
                r_b_pop_valid <= do_read;
            end
            if (do_write) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_read) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (go) begin
                r_b_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Bit store: entry = {timeout, value}
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr_ptr] <= {i_cmd.timeout, i_cmd.bit_val};
        end
        if (do_read) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_res_valid       = r_b_valid;
    assign o_res.bit_queued  = r_b_queued;
    assign o_res.bit_dropped = r_b_dropped;
    assign o_res.pop_valid   = r_b_pop_valid;
    assign o_res.pop_bit     = r_b_pop_valid && r_rd_data[0];
    assign o_res.pop_timeout = r_b_pop_valid && r_rd_data[1];
    assign o_res.fill_level  = LEVEL_W'(r_count);
    assign o_res.peak_fill   = LEVEL_W'(r_peak);

endmodule

@@ src/biphase_mark_edge_decoder.sv @@
// Top level of the biphase mark edge decoder: configuration registers,
// front end, command queue and back end. Depends on bmed_pkg and submodules.
//
// Biphase mark decoder fed with edge timestamps (32-bit, microseconds,
// wrapping) and pop requests on one valid/ready request channel; each request
// yields exactly one response on the valid/ready response channel. The front
// end subtracts the previous edge time, checks the interval against the
// whole-bit and half-bit windows, steps the three-phase decode machine and
// flags a decoded bit as a timeout when its distance to the previous decoded
// bit lies outside the whole-bit window. A two-entry command queue sits
// between front and back, so either side may stall on its own. The back end
// owns the FIFO_DEPTH x 2-bit bit store (one write or one registered read
// per cycle), its fill and peak counters, and the response register.
// Throughput: one request per clock, sustained, as long as responses are
// taken. From request accept to response valid a command passes the queue
// slot, then the response register. fill_level and peak_fill are the low
// six bits of the counts. The four window registers are written through a
// plain write port (index 0..3) and should only change while the block is idle.
module biphase_mark_edge_decoder #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  bmed_pkg::t_in_req            i_req,
    // response channel
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output bmed_pkg::t_out_res           o_res,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [bmed_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bmed_pkg::WIN_W-1:0]   i_cfg_data
);
    import bmed_pkg::*;

    t_cfg_regs r_cfg;

    logic      f_cmd_valid;
    logic      f_cmd_ready;
    t_cmd      f_cmd;
    logic      q_cmd_valid;
    logic      q_cmd_ready;
    t_cmd      q_cmd;

    // Window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_min <= FULL_MIN_RST;
            r_cfg.full_max <= FULL_MAX_RST;
            r_cfg.half_min <= HALF_MIN_RST;
            r_cfg.half_max <= HALF_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FULL_MIN: r_cfg.full_min <= i_cfg_data;
                REG_FULL_MAX: r_cfg.full_max <= i_cfg_data;
                REG_HALF_MIN: r_cfg.half_min <= i_cfg_data;
                REG_HALF_MAX: r_cfg.half_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify each request into a NOP, PUSH or POP command
    bmed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_cmd_valid (f_cmd_valid),
        .i_cmd_ready (f_cmd_ready),
        .o_cmd       (f_cmd)
    );

    bmed_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_cmd_valid),
        .o_push_ready (f_cmd_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_cmd_valid),
        .i_pop_ready  (q_cmd_ready),
        .o_pop_cmd    (q_cmd)
    );

    // FIFO, counters and response register
    bmed_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_cmd_valid),
        .o_cmd_ready (q_cmd_ready),
        .i_cmd       (q_cmd),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

@@ src/bmed_checker.sv @@
// Port-level checks for the biphase mark edge decoder, bound to the top.
// Depends on bmed_pkg and biphase_mark_edge_decoder.
module bmed_checker #(
    parameter int FIFO_DEPTH = 32
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 o_req_ready,
    input bmed_pkg::t_in_req    i_req,
    input logic                 o_res_valid,
    input logic                 i_res_ready,
    input bmed_pkg::t_out_res   o_res
);
    import bmed_pkg::*;

    // A stalled response holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("response changed while stalled");

    // A waiting request holds until taken
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_ready |=> i_req_valid && $stable(i_req))
        else $error("request changed while waiting");

    // Edge and pop flags never mix
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $countones({o_res.bit_queued, o_res.bit_dropped,
                                    o_res.pop_valid}) <= 1)
        else $error("response flags overlap");

    // Peak never falls below fill, and dropping only happens when full
    a_peak_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (FIFO_DEPTH < 64) |->
            o_res.fill_level <= o_res.peak_fill)
        else $error("fill above peak");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.bit_dropped && (FIFO_DEPTH < 64) |->
            o_res.fill_level == LEVEL_W'(FIFO_DEPTH))
        else $error("bit dropped while FIFO not full");

endmodule

bind biphase_mark_edge_decoder bmed_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_bmed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

@@ dv/biphase_mark_edge_decoder_check.sv @@
// Checker for the biphase mark edge decoder: watches the request, response
// and configuration ports, predicts each response and compares it.
// Depends on bmed_pkg.
module biphase_mark_edge_decoder_check
    import bmed_pkg::*;
#(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  t_in_req              i_req,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  t_out_res             i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WIN_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    t_cfg_regs         win;
    t_phase            phase;
    logic [TIME_W-1:0] last_edge;
    logic [TIME_W-1:0] last_bit;
    logic [1:0]        bit_store [FIFO_DEPTH];  // {timeout, value}
    int                wr_ptr;
    int                rd_ptr;
    int                fill;
    int                peak;
    t_out_res          due_results [$];

    function automatic logic in_win(logic [TIME_W-1:0] v, logic [WIN_W-1:0] lo,
                                    logic [WIN_W-1:0] hi);
        return v >= {8'd0, lo} && v <= {8'd0, hi};
    endfunction

    // Steps the decoder model by one request and returns the response it owes.
    function automatic t_out_res decode_request(t_in_req r);
        t_out_res          res;
        logic [TIME_W-1:0] ival;
        logic [TIME_W-1:0] spacing;
        logic              got_bit;
        logic              bit_val;
        res     = '0;
        got_bit = 1'b0;
        bit_val = 1'b0;
        if (r.func == FUNC_EDGE) begin
            ival      = r.edge_time - last_edge;
            last_edge = r.edge_time;
            case (phase)
                PH_START: begin
                    if (in_win(ival, win.full_min, win.full_max)) begin
                        got_bit = 1'b1;
                    end else if (in_win(ival, win.half_min, win.half_max)) begin
                        phase = PH_HALF;
                    end
                end
                PH_HALF: begin
                    if (in_win(ival, win.half_min, win.half_max)) begin
                        got_bit = 1'b1;
                        bit_val = 1'b1;
                    end
                    phase = PH_START;
                end
                default: phase = PH_START;
            endcase
            if (got_bit) begin
                spacing  = r.edge_time - last_bit;
                last_bit = r.edge_time;
                if (fill < FIFO_DEPTH) begin
                    bit_store[wr_ptr] = {!in_win(spacing, win.full_min, win.full_max),
                                         bit_val};
                    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                    fill++;
                    res.bit_queued = 1'b1;
                end else begin
                    res.bit_dropped = 1'b1;
                end
                if (fill > peak) peak = fill;
            end
        end else if (fill > 0) begin
            res.pop_valid   = 1'b1;
            res.pop_bit     = bit_store[rd_ptr][0];
            res.pop_timeout = bit_store[rd_ptr][1];
            rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
            fill--;
        end
        res.fill_level = fill[LEVEL_W-1:0];
        res.peak_fill  = peak[LEVEL_W-1:0];
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_result(t_out_res want, t_out_res got);
        check_field("bit_queued",  want.bit_queued,  got.bit_queued);
        check_field("bit_dropped", want.bit_dropped, got.bit_dropped);
        check_field("pop_valid",   want.pop_valid,   got.pop_valid);
        check_field("pop_bit",     want.pop_bit,     got.pop_bit);
        check_field("pop_timeout", want.pop_timeout, got.pop_timeout);
        check_field("fill_level",  want.fill_level,  got.fill_level);
        check_field("peak_fill",   want.peak_fill,   got.peak_fill);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win          = '{FULL_MIN_RST, FULL_MAX_RST, HALF_MIN_RST, HALF_MAX_RST};
            phase        = PH_WAIT;
            last_edge    = '0;
            last_bit     = '0;
            wr_ptr       = 0;
            rd_ptr       = 0;
            fill         = 0;
            peak         = 0;
            o_fail_count = 0;
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FULL_MIN: win.full_min = i_cfg_data;
                    REG_FULL_MAX: win.full_max = i_cfg_data;
                    REG_HALF_MIN: win.half_min = i_cfg_data;
                    REG_HALF_MAX: win.half_max = i_cfg_data;
                    default: ;
                endcase
            end
            // responses first: a response never belongs to a same-edge request
            if (i_res_valid && i_res_ready) begin
                if (due_results.size() == 0) begin
                    $error("response with no request outstanding");
                    o_fail_count++;
                end else begin
                    check_result(due_results.pop_front(), i_res);
                end
            end
            if (i_req_valid && i_req_ready) due_results.push_back(decode_request(i_req));
            o_pending <= due_results.size();
        end
    end

endmodule

@@ dv/biphase_mark_edge_decoder_test.sv @@
// Testbench top for the biphase mark edge decoder: clock, reset, request and
// configuration stimulus, response sink and verdict.
// Depends on bmed_pkg, the decoder RTL and biphase_mark_edge_decoder_check.
module biphase_mark_edge_decoder_test;
    import bmed_pkg::*;

    localparam int FIFO_DEPTH  = 32;
    localparam int CLK_PERIOD  = 8;
    localparam int RAND_ITEMS  = 1050;
    localparam int PHASE_ITEMS = 140;   // requests per window setting
    localparam int HOLD_CYCLES = 120;   // long receiver stall
    localparam int RUN_LIMIT   = 250_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    t_in_req              req       = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    t_out_res             res;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = REG_FULL_MIN;
    logic [WIN_W-1:0]     cfg_data  = '0;

    int                   fail_count;
    int                   pending;

    // Stimulus-side copy of the windows, used only to shape intervals.
    t_cfg_regs            win = '{FULL_MIN_RST, FULL_MAX_RST, HALF_MIN_RST, HALF_MAX_RST};
    logic [TIME_W-1:0]    line_time = '0;
    int                   n_sent = 0;
    bit                   calm = 1'b0;          // no idle cycles on either side
    bit                   hold_results = 1'b0;  // asks the sink for a long stall

    always begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    biphase_mark_edge_decoder #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    biphase_mark_edge_decoder_check #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) i_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req       (req),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Offers one request and returns at the edge that accepts it. Valid stays
    // high afterwards unless the next request starts with idle cycles.
    task automatic offer(input logic fn, input logic [TIME_W-1:0] t);
        int pause;
        pause = calm ? 0 : $urandom_range(0, 4);
        if (pause != 0) begin
            req_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{func: fn, edge_time: t};
        do @(posedge clk); while (!req_ready);
        n_sent++;
    endtask

    task automatic edge_at(input logic [TIME_W-1:0] t);
        line_time = t;
        offer(FUNC_EDGE, t);
    endtask

    task automatic edge_after(input logic [TIME_W-1:0] delta);
        edge_at(line_time + delta);
    endtask

    // Pop requests carry a random, ignored timestamp.
    task automatic pop();
        offer(FUNC_POP, $urandom);
    endtask

    // Drops valid and waits until every owed response has been taken.
    task automatic wait_idle();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
    endtask

    task automatic set_windows(input logic [WIN_W-1:0] fmin, input logic [WIN_W-1:0] fmax,
                               input logic [WIN_W-1:0] hmin, input logic [WIN_W-1:0] hmax);
        wait_idle();
        write_reg(REG_FULL_MIN, fmin);
        write_reg(REG_FULL_MAX, fmax);
        write_reg(REG_HALF_MIN, hmin);
        write_reg(REG_HALF_MAX, hmax);
        cfg_we <= 1'b0;
        win = '{fmin, fmax, hmin, hmax};
    endtask

    // Interval inside a window, biased toward its bounds. An empty window
    // (min above max) yields its min, which matches nothing.
    function automatic logic [TIME_W-1:0] pick_in(logic [WIN_W-1:0] lo, logic [WIN_W-1:0] hi);
        if (lo > hi) return {8'd0, lo};
        case ($urandom_range(0, 3))
            0:       return {8'd0, lo};
            1:       return {8'd0, hi};
            default: return {8'd0, lo} + $urandom_range(0, hi - lo);
        endcase
    endfunction

    // Intervals just outside the windows, or anything at all.
    function automatic logic [TIME_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return {8'd0, win.full_min} - 1;
            1:       return {8'd0, win.full_max} + 1;
            2:       return {8'd0, win.half_min} - 1;
            3:       return {8'd0, win.half_max} + 1;
            4:       return $urandom;
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    // One burst of line coding: a sync edge, then nbits encoded bits with
    // the odd corrupted edge, and pop requests mixed in at pop_pct percent.
    task automatic run_frame(input int nbits, input int pop_pct);
        if ($urandom_range(0, 7) == 0) edge_at($urandom);
        else edge_after(pick_noise());
        repeat (nbits) begin
            if ($urandom_range(0, 19) == 0) begin
                edge_after(pick_noise());
            end else if ($urandom_range(0, 1) == 0) begin
                edge_after(pick_in(win.full_min, win.full_max));
            end else begin
                edge_after(pick_in(win.half_min, win.half_max));
                edge_after(pick_in(win.half_min, win.half_max));
            end
            if ($urandom_range(0, 99) < pop_pct) pop();
        end
    endtask

    task automatic apply_setting(input int k);
        case (k)
            0: set_windows(24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF);       // all intervals up to 0xFFFFFF match
            1: set_windows(24'd100, 24'd200, 24'd40, 24'd110);          // windows overlap
            2: set_windows(24'hFFFFF0, 24'hFFFFFF, 24'h7FFFF0, 24'h800000);
            3: set_windows(24'd500, 24'd400, 24'd100, 24'd300);         // empty whole-bit window
            default: set_windows(FULL_MIN_RST, FULL_MAX_RST, HALF_MIN_RST, HALF_MAX_RST);
        endcase
    endtask

    // Response sink: random ready gaps, free-running stretches, and one long
    // stall on request from the stimulus.
    initial begin : result_sink
        int pause;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pause = calm ? 0 : $urandom_range(0, 4);
            if (pause != 0) begin
                res_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial begin : stimulus
        int k;
        int phase_start;
        int n_directed;
        int pop_pct;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset windows (whole 1800..2200,
        // half 800..1200). Pop on empty first, then the first edge only
        // records its time.
        pop();
        edge_at(32'hFFFF_FFFF);
        edge_after(32'd2000);   // wraps; 0 measured from the zero bit time
        edge_after(32'd1800);   // 0 at the lower bound
        edge_after(32'd2200);   // 0 at the upper bound
        edge_after(32'd2201);   // unmatched in start: ignored
        edge_after(32'd1799);   // unmatched in start: ignored
        edge_after(32'd800);    // half
        edge_after(32'd1200);   // second half: 1
        edge_after(32'd1201);
        edge_after(32'd799);
        edge_after(32'd1000);   // half
        edge_after(32'd3000);   // unmatched in half: back to start, no bit
        edge_after(32'd1000);
        edge_after(32'd1000);   // 1 with a wide spacing: timeout
        repeat (6) pop();       // drain all five, then pop on empty
        edge_at(32'd0);
        offer(FUNC_POP, 32'd0);
        n_directed = n_sent;

        // Receiver stalls while a long run of zeros overflows the FIFO and
        // backs up into the request channel; then the sender waits for every
        // response before emptying the FIFO.
        calm = 1'b0;
        hold_results = 1'b1;
        edge_after(pick_noise());
        repeat (40) edge_after(pick_in(win.full_min, win.full_max));
        wait_idle();
        repeat (36) pop();

        // Random line coding across the window settings in turn.
        for (k = 0; n_sent < n_directed + RAND_ITEMS; k++) begin
            apply_setting(k % 5);
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS) begin
                calm = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 3))
                    0:       pop_pct = 0;
                    1:       pop_pct = 20;
                    2:       pop_pct = 45;
                    default: pop_pct = 70;
                endcase
                run_frame($urandom_range(1, 40), pop_pct);
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) pop();
            end
        end

        calm = 1'b0;
        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("biphase_mark_edge_decoder: match");
        end else begin
            $display("biphase_mark_edge_decoder: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * RUN_LIMIT);
        $display("biphase_mark_edge_decoder: mismatch");
        $finish;
    end

endmodule
